// ===== design/swa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants for the SIMT word ALU
// Operation codes, lane count and the classified item passed front to back.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int LANES = 4;
  localparam int WORD_W = 32;
  localparam int DIV_STEPS = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_SLL  = 4'd2,
    OP_SRL  = 4'd3,
    OP_SRA  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_DIVU = 4'd7,
    OP_REM  = 4'd8,
    OP_REMU = 4'd9
  } op_t;

  // Decoded item handed from the front end to the back end
  typedef struct packed {
    logic [3:0]                    action;
    logic [LANES-1:0]              wmask;
    logic                          muldiv;
    logic [LANES-1:0][WORD_W-1:0]  a;
    logic [LANES-1:0][WORD_W-1:0]  b;
  } item_t;

endpackage
`default_nettype wire

// ===== design/swa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swa_front: item intake and classification
// Decodes the action, forms the write mask and queues items for the back end.
// ----------------------------------------------------------------------------
module swa_front import swa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [3:0]             action,
  input  wire logic [LANES-1:0]       lane_mask,
  input  wire logic [LANES-1:0][WORD_W-1:0] a_in,
  input  wire logic [LANES-1:0][WORD_W-1:0] b_in,
  output logic                        q_valid,
  input  wire logic                   q_pop,
  output item_t                       q_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;
  logic            known;
  item_t           dec;

  // Classification
  always_comb begin
    known      = (action <= 4'(OP_REMU));
    dec.action = action;
    dec.wmask  = known ? lane_mask : '0;
    dec.muldiv = known && (action >= 4'(OP_MUL));
    dec.a      = a_in;
    dec.b      = b_in;
  end

  assign in_stall = (count == (PW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= dec;
  end

endmodule
`default_nettype wire

// ===== design/swa_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swa_lane: one lane's word datapath
// Pipelined: stage 0 operand prep and simple ops, 32 divide stages (one
// quotient bit each), registered multiplier, final fixup.
// ----------------------------------------------------------------------------
module swa_lane import swa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [3:0]        action,
  input  wire logic              active,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0]      result
);

  typedef struct packed {
    logic [WORD_W-1:0] simple;
    logic              use_simple;
    logic              is_mul;
    logic              is_rem;
    logic              neg_q;
    logic              neg_r;
    logic              bzero;
    logic [WORD_W-1:0] a_orig;
    logic [WORD_W-1:0] div_d;
    logic [WORD_W-1:0] rem_p;
    logic [WORD_W-1:0] quo;
  } st_t;

  st_t               st [DIV_STEPS+1];
  st_t               s0;
  logic              sgn;
  logic [4:0]        sh;
  logic [WORD_W-1:0] ua;
  logic [WORD_W-1:0] ub;
  logic [WORD_W-1:0] mul_lo;

  // Stage 0: simple ops and divide operand prep
  always_comb begin
    sh  = b[4:0];
    sgn = (action == 4'(OP_DIV)) || (action == 4'(OP_REM));
    ua  = (sgn && a[WORD_W-1]) ? (~a + 1'b1) : a;
    ub  = (sgn && b[WORD_W-1]) ? (~b + 1'b1) : b;
    s0  = '0;
    s0.use_simple = 1'b1;
    unique case (action)
      4'(OP_ADD): s0.simple = a + b;
      4'(OP_SUB): s0.simple = a - b;
      4'(OP_SLL): s0.simple = a << sh;
      4'(OP_SRL): s0.simple = a >> sh;
      4'(OP_SRA): s0.simple = WORD_W'($signed(a) >>> sh);
      4'(OP_MUL): begin
        s0.use_simple = 1'b0;
        s0.is_mul     = 1'b1;
      end
      4'(OP_DIV), 4'(OP_DIVU), 4'(OP_REM), 4'(OP_REMU): s0.use_simple = 1'b0;
      default: s0.simple = '0;
    endcase
    if (!active) begin
      s0.use_simple = 1'b1;
      s0.simple     = '0;
    end
    s0.is_rem = (action == 4'(OP_REM)) || (action == 4'(OP_REMU));
    s0.neg_q  = sgn && (a[WORD_W-1] ^ b[WORD_W-1]);
    s0.neg_r  = sgn && a[WORD_W-1];
    s0.bzero  = (b == '0);
    s0.a_orig = a;
    s0.div_d  = ub;
    s0.quo    = ua;
    s0.rem_p  = s0.is_mul ? b : '0;
  end

  // Restoring divide step: partial remainder kept one bit wider for the compare
  function automatic st_t div_step(st_t s);
    st_t             nx;
    logic [WORD_W:0]   pr;
    logic [WORD_W+1:0] trial;
    nx    = s;
    pr    = {s.rem_p, s.quo[WORD_W-1]};
    trial = {1'b0, pr} - {2'b00, s.div_d};
    if (!s.use_simple && !s.is_mul) begin
      nx.rem_p = trial[WORD_W+1] ? pr[WORD_W-1:0] : trial[WORD_W-1:0];
      nx.quo   = {s.quo[WORD_W-2:0], ~trial[WORD_W+1]};
    end
    return nx;
  endfunction

  // Stage registers: one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= s0;
      for (int k = 0; k < DIV_STEPS; k++) st[k+1] <= div_step(st[k]);
    end
  end

  // Multiply (operands parked in a_orig/rem_p) and result fixup
  st_t               fin;
  logic [WORD_W-1:0] mres;
  logic [WORD_W-1:0] q_s;
  logic [WORD_W-1:0] r_s;

  assign fin    = st[DIV_STEPS];
  assign mul_lo = st[0].a_orig * st[0].rem_p;

  // Multiply result rides alongside the divide stages
  logic [WORD_W-1:0] mpipe [DIV_STEPS];
  always_ff @(posedge clk) begin
    if (adv) begin
      mpipe[0] <= mul_lo;
      for (int i = 1; i < DIV_STEPS; i++) mpipe[i] <= mpipe[i-1];
    end
  end
  assign mres = mpipe[DIV_STEPS-1];

  always_comb begin
    q_s = fin.neg_q ? (~fin.quo + 1'b1) : fin.quo;
    r_s = fin.neg_r ? (~fin.rem_p + 1'b1) : fin.rem_p;
    priority if (fin.use_simple) result = fin.simple;
    else if (fin.is_mul) result = mres;
    else if (fin.bzero) result = fin.is_rem ? fin.a_orig : '1;
    else result = fin.is_rem ? r_s : q_s;
  end

endmodule
`default_nettype wire

// ===== design/swa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swa_back: lane execution pipeline and output register
// Lanes advance together; a valid bit per stage tracks items in flight.
// ----------------------------------------------------------------------------
module swa_back import swa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  input  wire item_t                  q_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [LANES-1:0][WORD_W-1:0] res,
  output logic [LANES-1:0]            wmask_o,
  output logic                        muldiv_o
);

  localparam int DEPTH = DIV_STEPS + 1;

  logic [DEPTH-1:0]   vld;
  logic [LANES-1:0]   wm   [DEPTH];
  logic               md   [DEPTH];
  logic               adv;

  // Whole pipe moves unless the last stage holds an unaccepted item
  assign adv       = !(vld[DEPTH-1] && out_stall);
  assign q_pop     = adv && q_valid;
  assign out_valid = vld[DEPTH-1];
  assign wmask_o   = wm[DEPTH-1];
  assign muldiv_o  = md[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], q_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wm[0] <= q_item.wmask;
      md[0] <= q_item.muldiv;
      for (int i = 1; i < DEPTH; i++) begin
        wm[i] <= wm[i-1];
        md[i] <= md[i-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    swa_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .action (q_item.action),
      .active (q_item.wmask[l]),
      .a      (q_item.a[l]),
      .b      (q_item.b[l]),
      .result (res[l])
    );
  end

endmodule
`default_nettype wire

// ===== design/simt_word_alu_with_muldiv_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// simt_word_alu_with_muldiv_unit: four-lane SIMT word ALU with mul/div
// Front end classifies items into a two-entry queue; the back end runs all
// lanes through a 33-stage pipeline with per-lane pipelined restoring dividers.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_valid/in_stall   action, lane_mask, a_lane0..3, b_lane0..3
//  out      out_valid/out_stall result_lane0..3, write_mask, used_muldiv
//
// One item per cycle sustained while out_stall is low; items pass the queue
// and 33 stages set by the 32 one-bit divide steps. Reset clears queue and
// stage valid bits only. out_stall freezes the whole pipe; queue holds two.
module simt_word_alu_with_muldiv_unit import swa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  action,
  input  wire logic [3:0]  lane_mask,
  input  wire logic [31:0] a_lane0,
  input  wire logic [31:0] a_lane1,
  input  wire logic [31:0] a_lane2,
  input  wire logic [31:0] a_lane3,
  input  wire logic [31:0] b_lane0,
  input  wire logic [31:0] b_lane1,
  input  wire logic [31:0] b_lane2,
  input  wire logic [31:0] b_lane3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] result_lane0,
  output logic signed [31:0] result_lane1,
  output logic signed [31:0] result_lane2,
  output logic signed [31:0] result_lane3,
  output logic [3:0]       write_mask,
  output logic             used_muldiv
);

  logic [LANES-1:0][WORD_W-1:0] a_v;
  logic [LANES-1:0][WORD_W-1:0] b_v;
  logic [LANES-1:0][WORD_W-1:0] res;
  logic                         q_valid;
  logic                         q_pop;
  item_t                        q_item;

  assign a_v = {a_lane3, a_lane2, a_lane1, a_lane0};
  assign b_v = {b_lane3, b_lane2, b_lane1, b_lane0};

  swa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .lane_mask (lane_mask),
    .a_in      (a_v),
    .b_in      (b_v),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  swa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .wmask_o   (write_mask),
    .muldiv_o  (used_muldiv)
  );

  assign result_lane0 = res[0];
  assign result_lane1 = res[1];
  assign result_lane2 = res[2];
  assign result_lane3 = res[3];

endmodule
`default_nettype wire
